/* design/ppm_stream_decoder_defines.svh */
// Assertion macros for the PPM stream decoder.
// No dependencies.
`ifndef PPM_STREAM_DECODER_DEFINES_SVH
`define PPM_STREAM_DECODER_DEFINES_SVH
// implication checked every edge outside reset
`define PPM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");
// next-cycle implication
`define PPM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: label failed");
`endif

/* design/ppm_pkg.sv */
// Shared types and constants for the PPM stream decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppm_pkg;
   localparam int unsigned MaxDim = 4096;
   localparam logic [16:0] AccMax = 17'h1FFFF;
   localparam logic [2:0] KIND_HEADER = 3'd0;
   localparam logic [2:0] KIND_PIXEL = 3'd1;
   localparam logic [2:0] KIND_BADMAGIC = 3'd2;
   localparam logic [2:0] KIND_BADHEADER = 3'd3;
   localparam logic [2:0] KIND_TRUNC = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [12:0] image_w;
      logic [12:0] image_h;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        final_pixel;
   } rsp_type;
endpackage
`default_nettype wire

/* design/ppm_scaler.sv */
// Iterative restoring divider: scales one sample to (v+1)*255/maxval - 1, clamped to 0..255.
// Depends on ppm_stream_decoder_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
module ppm_scaler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [16:0] sample,
   input  wire logic [16:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [7:0]       result
);
   // dividend up to (0x1FFFF+1)*255 < 2^25
   logic [24:0] dvd_ff, dvd_in;
   logic [24:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] div_ff, div_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in, zero_ff, zero_in;
   logic [17:0] trial;
   logic [24:0] prod;

   assign prod = ({8'd0, sample} + 25'd1) * 25'd255;
   assign trial = {rem_ff, dvd_ff[24]} - {1'b0, div_ff};

   always_comb begin
      dvd_in = dvd_ff; quo_in = quo_ff; rem_in = rem_ff; div_in = div_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0; zero_in = zero_ff;
      if (start) begin
         dvd_in = prod; quo_in = '0; rem_in = '0; div_in = divisor;
         cnt_in = 5'd25; busy_in = 1'b1;
         zero_in = (sample == 17'd0) || (divisor == 17'd0);
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[23:0], 1'b0};
         if (!trial[17]) begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[23:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], dvd_ff[24]};
            quo_in = {quo_ff[23:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in; quo_ff <= quo_in; rem_ff <= rem_in;
      div_ff <= div_in; zero_ff <= zero_in;
   end

   always_comb begin
      if (zero_ff || quo_ff == 25'd0) result = 8'd0;
      else if (quo_ff > 25'd256) result = 8'd255;
      else result = 8'(quo_ff - 25'd1);
   end
   assign busy = busy_ff;
   assign done = done_ff;

   `include "ppm_stream_decoder_defines.svh"
   `PPM_ASSERT_NXT(a_done_pulse, clock, reset, done_ff, !done_ff)
   `PPM_ASSERT_IMP(a_no_restart, clock, reset, busy_ff, !start)
   `PPM_ASSERT_NXT(a_start_busy, clock, reset, start, busy_ff)
endmodule
`default_nettype wire

/* design/ppm_stream_decoder.sv */
// PPM stream decoder top level: byte parser, sequencer and shared scaler.
// Depends on ppm_pkg, ppm_scaler and ppm_stream_decoder_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
// Takes a P3 or P6 PPM file one byte per transfer and returns a header
// result, then one result per pixel, or an error. A byte that completes a
// colour component occupies the shared 25-step divider, and no further byte
// is accepted until the divider has finished and its result is stored.
// Results sit in an output register; a waiting result blocks further bytes.
module ppm_stream_decoder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ppm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ppm_pkg::rsp_type      rsp_data
);
   localparam logic [2:0] PH_MAGIC0 = 3'd0;
   localparam logic [2:0] PH_MAGIC1 = 3'd1;
   localparam logic [2:0] PH_HEADER = 3'd2;
   localparam logic [2:0] PH_PIXELS = 3'd3;
   localparam logic [2:0] PH_IDLE = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic        bin_ff, bin_in, wide_ff, wide_in, cmt_ff, cmt_in;
   logic [16:0] acc_ff, acc_in;
   logic        hd_ff, hd_in;
   logic [12:0] w_ff, w_in, h_ff, h_in;
   logic [16:0] maxv_ff, maxv_in;
   logic [1:0]  ci_ff, ci_in;
   logic [8:0]  hb_ff, hb_in;
   logic [7:0]  r_ff, r_in, g_ff, g_in;
   logic [24:0] left_ff, left_in;
   // pending completion
   logic        wait_ff, wait_in, plast_ff, plast_in;
   logic        ov_ff, ov_in;
   ppm_pkg::rsp_type ob_ff, ob_in;

   logic        sc_start, sc_busy, sc_done;
   logic [16:0] sc_sample;
   logic [7:0]  sc_res;

   ppm_scaler u_scaler (
      .clock(clock), .reset(reset), .start(sc_start), .sample(sc_sample),
      .divisor(maxv_ff), .busy(sc_busy), .done(sc_done), .result(sc_res)
   );

   logic        acc_fire;
   logic [7:0]  b;
   logic        last, ws, dig;
   logic [20:0] acc_x;
   logic [16:0] acc_dig;

   assign acc_fire = req_valid && req_ready;
   assign b = req_data.data_byte;
   assign last = req_data.end_of_data;
   assign ws = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
   assign dig = (b >= 8'h30) && (b <= 8'h39);
   assign acc_x = {4'd0, acc_ff} * 21'd10 + {17'd0, b[3:0]};
   assign acc_dig = (acc_x > {4'd0, ppm_pkg::AccMax}) ? ppm_pkg::AccMax : acc_x[16:0];
   assign req_ready = !ov_ff && !wait_ff && !sc_busy && !sc_done;

   task automatic do_reset();
      phase_in = PH_MAGIC0; bin_in = 1'b0; wide_in = 1'b0; cmt_in = 1'b0;
      acc_in = '0; hd_in = 1'b0; w_in = '0; h_in = '0; maxv_in = '0;
      ci_in = '0; hb_in = '0; r_in = '0; g_in = '0; left_in = '0;
   endtask

   always_comb begin
      logic [2:0]  kind;
      logic        emit, err;
      logic [16:0] v;
      logic [24:0] lft;
      phase_in = phase_ff; bin_in = bin_ff; wide_in = wide_ff; cmt_in = cmt_ff;
      acc_in = acc_ff; hd_in = hd_ff; w_in = w_ff; h_in = h_ff;
      maxv_in = maxv_ff; ci_in = ci_ff; hb_in = hb_ff; r_in = r_ff;
      g_in = g_ff; left_in = left_ff; wait_in = wait_ff; plast_in = plast_ff;
      ov_in = ov_ff; ob_in = ob_ff;
      sc_start = 1'b0; sc_sample = '0;
      kind = ppm_pkg::KIND_HEADER; emit = 1'b0; err = 1'b0; v = '0; lft = '0;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      if (sc_done) begin
         wait_in = 1'b0;
         emit = 1'b0;
         unique case (ci_ff)
            2'd0: begin r_in = sc_res; ci_in = 2'd1; end
            2'd1: begin g_in = sc_res; ci_in = 2'd2; end
            default: begin
               ci_in = 2'd0;
               lft = (left_ff != '0) ? left_ff - 25'd1 : left_ff;
               left_in = lft;
               emit = 1'b1;
               kind = ppm_pkg::KIND_PIXEL;
               ob_in.red = r_ff; ob_in.green = g_ff; ob_in.blue = sc_res;
               ob_in.final_pixel = (lft == '0);
               if (lft == '0) phase_in = PH_IDLE;
            end
         endcase
         if (plast_ff && !(emit && lft == '0)) begin
            emit = 1'b1;
            kind = ppm_pkg::KIND_TRUNC;
            ob_in.red = '0; ob_in.green = '0; ob_in.blue = '0;
            ob_in.final_pixel = 1'b0;
         end
         if (emit) begin
            ov_in = 1'b1; ob_in.kind = kind; ob_in.image_w = w_ff;
            ob_in.image_h = h_ff;
         end
         if (plast_ff) do_reset();
      end else if (acc_fire) begin
         priority if (phase_ff == PH_MAGIC0) begin
            if (b == 8'h50) phase_in = PH_MAGIC1;
            else begin err = 1'b1; kind = ppm_pkg::KIND_BADMAGIC; end
         end else if (phase_ff == PH_MAGIC1) begin
            if (b == 8'h33 || b == 8'h36) begin
               bin_in = (b == 8'h36); phase_in = PH_HEADER;
            end else begin err = 1'b1; kind = ppm_pkg::KIND_BADMAGIC; end
         end else if (phase_ff == PH_HEADER) begin
            if (cmt_ff) begin
               if (b == 8'h0A) cmt_in = 1'b0;
            end else if (dig) begin
               acc_in = acc_dig; hd_in = 1'b1;
            end else begin
               if (hd_ff) begin
                  v = acc_ff; acc_in = '0; hd_in = 1'b0;
                  if (ci_ff != 2'd2) begin
                     if (v == '0 || v > 17'(ppm_pkg::MaxDim)) err = 1'b1;
                     else begin
                        if (ci_ff == 2'd0) w_in = v[12:0];
                        else h_in = v[12:0];
                        ci_in = ci_ff + 2'd1;
                     end
                  end else begin
                     if (v == '0 || v > 17'hFFFF || !ws) err = 1'b1;
                     else begin
                        maxv_in = v; wide_in = (v > 17'd255);
                        left_in = {12'd0, w_ff} * {12'd0, h_ff};
                        ci_in = 2'd0; phase_in = PH_PIXELS;
                        emit = 1'b1; kind = ppm_pkg::KIND_HEADER;
                     end
                  end
               end
               if (!err && !emit) begin
                  if (b == 8'h23) cmt_in = 1'b1;
                  else if (!ws) err = 1'b1;
               end
               if (err) kind = ppm_pkg::KIND_BADHEADER;
            end
         end else if (phase_ff == PH_PIXELS) begin
            if (bin_ff) begin
               if (!wide_ff) begin
                  sc_start = 1'b1; sc_sample = {9'd0, b};
               end else if (hb_ff[8]) begin
                  sc_start = 1'b1; sc_sample = {1'b0, hb_ff[7:0], b}; hb_in = '0;
               end else hb_in = {1'b1, b};
            end else if (cmt_ff) begin
               if (b == 8'h0A) cmt_in = 1'b0;
            end else if (dig) begin
               if (last) begin
                  sc_start = 1'b1; sc_sample = acc_dig; acc_in = '0; hd_in = 1'b0;
               end else begin
                  acc_in = acc_dig; hd_in = 1'b1;
               end
            end else begin
               if (b == 8'h23) cmt_in = 1'b1;
               if (hd_ff) begin
                  sc_start = 1'b1; sc_sample = acc_ff; acc_in = '0; hd_in = 1'b0;
               end
            end
         end else begin
         end
         if (err) begin
            phase_in = PH_IDLE; emit = 1'b1;
         end
         if (sc_start) begin
            wait_in = 1'b1; plast_in = last;
         end else begin
            if (last && phase_ff != PH_IDLE && !err) begin
               emit = 1'b1; kind = ppm_pkg::KIND_TRUNC;
            end
            if (emit) begin
               ov_in = 1'b1;
               ob_in.kind = kind; ob_in.image_w = w_in; ob_in.image_h = h_in;
               ob_in.red = '0; ob_in.green = '0; ob_in.blue = '0;
               ob_in.final_pixel = 1'b0;
            end
            if (last) do_reset();
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC0; bin_ff <= 1'b0; wide_ff <= 1'b0; cmt_ff <= 1'b0;
         acc_ff <= '0; hd_ff <= 1'b0; w_ff <= '0; h_ff <= '0; maxv_ff <= '0;
         ci_ff <= '0; hb_ff <= '0; r_ff <= '0; g_ff <= '0; left_ff <= '0;
         wait_ff <= 1'b0; plast_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; bin_ff <= bin_in; wide_ff <= wide_in;
         cmt_ff <= cmt_in; acc_ff <= acc_in; hd_ff <= hd_in; w_ff <= w_in;
         h_ff <= h_in; maxv_ff <= maxv_in; ci_ff <= ci_in; hb_ff <= hb_in;
         r_ff <= r_in; g_ff <= g_in; left_ff <= left_in; wait_ff <= wait_in;
         plast_ff <= plast_in; ov_ff <= ov_in;
      end
      ob_ff <= ob_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_data = ob_ff;

   `include "ppm_stream_decoder_defines.svh"
   `PPM_ASSERT_IMP(a_done_when_wait, clock, reset, sc_done, wait_ff)
   `PPM_ASSERT_IMP(a_no_accept_busy, clock, reset, wait_ff, !req_ready)
   `PPM_ASSERT_NXT(a_start_wait, clock, reset, sc_start, wait_ff)
   `PPM_ASSERT_IMP(a_kind_range, clock, reset, rsp_valid, rsp_data.kind <= ppm_pkg::KIND_TRUNC)
endmodule
`default_nettype wire
